FILE: hdl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted symbol frequency list: shared package
// Sizes, payload structs, inter-cell link and control structs, state codes
// and the count clamp used on the result port.
// ----------------------------------------------------------------------------
package sfl_pkg;

   localparam int ALPHABET_SIZE  = 256;
   localparam int COUNT_BITS     = 32;
   localparam int SYMBOL_BITS    = 8;
   localparam int RANK_BITS      = 8;
   localparam int OUT_COUNT_BITS = 32;
   localparam int DISTINCT_BITS  = 9;
   localparam int IDX_W          = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int TOTAL_W        = $clog2(ALPHABET_SIZE + 1);
   localparam int SYM_CMP_W      = SYMBOL_BITS + 1;

   localparam logic ACT_COUNT = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [SYMBOL_BITS-1:0] sym_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [TOTAL_W-1:0]     total_type;

   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      logic                 action;
      logic [7:0]           symbol;
      logic [7:0]           rank;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_symbol;
      logic [31:0]          out_count;
      logic [7:0]           out_rank;
      logic                 entry_valid;
      logic [8:0]           distinct_symbols;
   } rsp_type;

   typedef struct packed {
      sym_type   sym;
      count_type cnt;
      logic      ge;
      logic      valid;
   } link_type;

   typedef struct packed {
      logic      enable;
      logic      sat;
      idx_type   pos;
      sym_type   new_sym;
      count_type new_cnt;
   } update_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   localparam link_type LINK_HEAD = '{sym: '0, cnt: '0, ge: 1'b1, valid: 1'b1};
   localparam link_type LINK_TAIL = '{sym: '0, cnt: '0, ge: 1'b0, valid: 1'b0};

   function automatic logic [OUT_COUNT_BITS-1:0] clamp_count(input count_type c);
      logic [OUT_COUNT_BITS-1:0] r;
      r = OUT_COUNT_BITS'(c);
      if ((c >> OUT_COUNT_BITS) != '0) begin
         r = '1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/sfl_cell.sv
// ----------------------------------------------------------------------------
// Sorted symbol frequency list: list cell
// Holds one ranked entry, matches it against a lookup and takes part in the
// remove and reinsert shift by pulling from a neighbor or taking the new entry.
// ----------------------------------------------------------------------------
module sfl_cell (
   input  logic                clock,
   input  sfl_pkg::idx_type    cell_index,
   input  sfl_pkg::total_type  total,
   input  sfl_pkg::req_type    lookup,
   input  sfl_pkg::update_type upd,
   input  sfl_pkg::link_type   left_link,
   input  sfl_pkg::link_type   right_link,
   output sfl_pkg::link_type   link_out,
   output logic                match,
   output logic                take_new
);
   import sfl_pkg::*;

   sym_type   sym_ff, sym_in;
   count_type cnt_ff, cnt_in;
   logic      valid;
   logic      ge_self;
   logic      at_m, le_m, ge_m;
   logic      take_left, take_right;

   always_comb begin
      valid   = TOTAL_W'(cell_index) < total;
      ge_self = cnt_ff >= upd.new_cnt;
      at_m    = cell_index == upd.pos;
      le_m    = cell_index <= upd.pos;
      ge_m    = cell_index >= upd.pos;

      if (lookup.action == ACT_READ) begin
         match = valid && (RANK_BITS'(cell_index) == lookup.rank);
      end else begin
         match = valid && (sym_ff == lookup.symbol);
      end

      take_left  = 1'b0;
      take_right = 1'b0;
      take_new   = 1'b0;
      if (upd.enable) begin
         if (!upd.sat) begin
            take_left = le_m && !left_link.ge;
            take_new  = le_m && left_link.ge && (at_m || !ge_self);
         end else begin
            take_right = ge_m && right_link.valid && right_link.ge;
            take_new   = ge_m && !take_right && (at_m || (valid && ge_self));
         end
      end

      sym_in = sym_ff;
      cnt_in = cnt_ff;
      if (take_new) begin
         sym_in = upd.new_sym;
         cnt_in = upd.new_cnt;
      end else if (take_left) begin
         sym_in = left_link.sym;
         cnt_in = left_link.cnt;
      end else if (take_right) begin
         sym_in = right_link.sym;
         cnt_in = right_link.cnt;
      end

      link_out = '{sym: sym_ff, cnt: cnt_ff, ge: ge_self, valid: valid};
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      cnt_ff <= cnt_in;
   end

endmodule

FILE: hdl/sorted_symbol_frequency_list.sv
// ----------------------------------------------------------------------------
// Sorted symbol frequency list: top level
// Row of list cells kept in falling count order, with lookup, update
// control and the result register.
// ----------------------------------------------------------------------------
// A transaction is taken on a rising edge where start is high and busy is low.
// A count transaction adds one occurrence of req_payload.symbol and reports the
// symbol, its new count and its new rank. A read transaction reports the entry
// held at req_payload.rank, with entry_valid low past the end of the list.
// Steps: the accept cycle compares every cell with the request and selects the
// hit entry; in the update state a count shifts the cells one place to take
// the entry out and put it back at its new rank (a read leaves the list alone).
// The result appears on rsp_payload with rsp_valid high for one cycle right
// after that; busy is high in the update state only, so no new transaction is
// taken before the update is done. The receiver cannot stall; every result is
// taken in its strobe cycle. Reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_symbol_frequency_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sfl_pkg::req_type req_payload,
   output logic             rsp_valid,
   output sfl_pkg::rsp_type rsp_payload
);
   import sfl_pkg::*;

   state_type  state_ff, state_in;
   total_type  total_ff, total_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       op_ff;
   sym_type    sym_ff;
   logic [7:0] rank_ff;
   logic       found_ff;
   logic       in_alpha_ff;
   sym_type    hit_sym_ff;
   count_type  hit_cnt_ff;
   count_type  new_cnt_ff;
   logic       sat_ff;
   idx_type    pos_ff;

   logic       accept;
   update_type upd;

   link_type   links   [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] match;
   logic [ALPHABET_SIZE-1:0] take_new;

   logic       any_match;
   sym_type    hit_sym;
   count_type  hit_cnt;
   idx_type    hit_idx;
   idx_type    new_rank;

   for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
      link_type left_l, right_l;
      if (g == 0) begin : g_head
         assign left_l = LINK_HEAD;
      end else begin : g_mid_l
         assign left_l = links[g-1];
      end
      if (g == ALPHABET_SIZE - 1) begin : g_tail
         assign right_l = LINK_TAIL;
      end else begin : g_mid_r
         assign right_l = links[g+1];
      end
      sfl_cell u_cell (
         .clock      (clock),
         .cell_index (idx_type'(g)),
         .total      (total_ff),
         .lookup     (req_payload),
         .upd        (upd),
         .left_link  (left_l),
         .right_link (right_l),
         .link_out   (links[g]),
         .match      (match[g]),
         .take_new   (take_new[g])
      );
   end

   always_comb begin
      any_match = 1'b0;
      hit_sym   = '0;
      hit_cnt   = '0;
      hit_idx   = '0;
      new_rank  = '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         any_match = any_match | match[i];
         hit_sym   = hit_sym | ({SYMBOL_BITS{match[i]}} & links[i].sym);
         hit_cnt   = hit_cnt | ({COUNT_BITS{match[i]}} & links[i].cnt);
         hit_idx   = hit_idx | ({IDX_W{match[i]}} & idx_type'(i));
         new_rank  = new_rank | ({IDX_W{take_new[i]}} & idx_type'(i));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy         = state_ff == ST_UPDATE;
      accept       = start && (state_ff == ST_IDLE);
      rsp_valid_in = state_ff == ST_UPDATE;
      upd.enable   = (state_ff == ST_UPDATE) && (op_ff == ACT_COUNT) && in_alpha_ff;
      upd.sat      = sat_ff;
      upd.pos      = pos_ff;
      upd.new_sym  = sym_ff;
      upd.new_cnt  = new_cnt_ff;
   end

   always_comb begin
      total_in = total_ff;
      if (upd.enable && !found_ff) begin
         total_in = TOTAL_W'(total_ff + 1'b1);
      end

      rsp_in = rsp_ff;
      if (op_ff == ACT_READ) begin
         rsp_in.out_symbol  = hit_sym_ff;
         rsp_in.out_count   = clamp_count(hit_cnt_ff);
         rsp_in.out_rank    = rank_ff;
         rsp_in.entry_valid = found_ff;
      end else if (!in_alpha_ff) begin
         rsp_in.out_symbol  = sym_ff;
         rsp_in.out_count   = '0;
         rsp_in.out_rank    = '0;
         rsp_in.entry_valid = 1'b0;
      end else begin
         rsp_in.out_symbol  = sym_ff;
         rsp_in.out_count   = clamp_count(new_cnt_ff);
         rsp_in.out_rank    = RANK_BITS'(new_rank);
         rsp_in.entry_valid = 1'b1;
      end
      rsp_in.distinct_symbols = DISTINCT_BITS'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_payload.action;
         sym_ff      <= req_payload.symbol;
         rank_ff     <= req_payload.rank;
         found_ff    <= any_match;
         in_alpha_ff <= SYM_CMP_W'(req_payload.symbol) < SYM_CMP_W'(ALPHABET_SIZE);
         hit_sym_ff  <= hit_sym;
         hit_cnt_ff  <= hit_cnt;
         sat_ff      <= any_match && (hit_cnt == COUNT_MAX);
         pos_ff      <= any_match ? hit_idx : IDX_W'(total_ff);
         if (!any_match) begin
            new_cnt_ff <= count_type'(1);
         end else if (hit_cnt == COUNT_MAX) begin
            new_cnt_ff <= COUNT_MAX;
         end else begin
            new_cnt_ff <= hit_cnt + count_type'(1);
         end
      end
      if (state_ff == ST_UPDATE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe without a preceding update cycle");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one cell matched the lookup");

   a_one_insert: assert property (@(posedge clock) disable iff (reset)
      upd.enable |-> $onehot(take_new))
      else $error("count update did not place the entry in exactly one cell");

   a_no_insert_idle: assert property (@(posedge clock) disable iff (reset)
      !upd.enable |-> (take_new == '0))
      else $error("cell took a new entry outside a count update");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      TOTAL_W'(ALPHABET_SIZE) >= total_ff)
      else $error("list size exceeds the alphabet");

endmodule

FILE: verif/sorted_symbol_frequency_list_tb.sv
// ----------------------------------------------------------------------------
// Sorted symbol frequency list: testbench
// Drives count and read transactions through the start/busy handshake, keeps
// its own ranked list of symbols and counts, and checks every result strobe
// field by field against the oldest predicted result. A short directed
// sequence covers the empty list, ties and reads past the end. Random traffic
// in three idling phases follows and fills the list completely.
// ----------------------------------------------------------------------------
module sorted_symbol_frequency_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfl_pkg::*;

   class freq_scoreboard;
      rsp_type     expected_results[$];
      sym_type     ranked_sym[ALPHABET_SIZE];
      count_type   ranked_cnt[ALPHABET_SIZE];
      int unsigned list_len;
      int unsigned failures;

      function new();
         list_len = 0;
         failures = 0;
      endfunction

      function logic [31:0] port_count(input count_type c);
         logic [63:0] wide;
         wide = 64'(c);
         return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      endfunction

      function void note_request(input req_type item);
         rsp_type     e;
         int unsigned i;
         int unsigned pos;
         int unsigned n;
         count_type   c;
         e = '0;
         n = list_len;
         if (item.action == ACT_READ) begin
            e.out_rank = item.rank;
            if (item.rank < n) begin
               e.out_symbol  = ranked_sym[item.rank];
               e.out_count   = port_count(ranked_cnt[item.rank]);
               e.entry_valid = 1'b1;
            end
         end else if (int'(item.symbol) >= ALPHABET_SIZE) begin
            e.out_symbol = item.symbol;
         end else begin
            i = 0;
            c = count_type'(1);
            while (i < n && ranked_sym[i] != item.symbol) i++;
            if (i < n) begin
               c = ranked_cnt[i];
               if (c != COUNT_MAX) c = c + 1'b1;
               for (; i + 1 < n; i++) begin
                  ranked_sym[i] = ranked_sym[i + 1];
                  ranked_cnt[i] = ranked_cnt[i + 1];
               end
               n--;
            end
            pos = n;
            while (pos > 0 && ranked_cnt[pos - 1] < c) begin
               ranked_sym[pos] = ranked_sym[pos - 1];
               ranked_cnt[pos] = ranked_cnt[pos - 1];
               pos--;
            end
            ranked_sym[pos] = item.symbol;
            ranked_cnt[pos] = c;
            n++;
            list_len      = n;
            e.out_symbol  = item.symbol;
            e.out_count   = port_count(c);
            e.out_rank    = pos[7:0];
            e.entry_valid = 1'b1;
         end
         e.distinct_symbols = list_len[8:0];
         expected_results.push_back(e);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (expected_results.size() == 0) begin
            $error("result with no transaction outstanding: %p", got);
            failures++;
            return;
         end
         e = expected_results.pop_front();
         if (got.out_symbol !== e.out_symbol) begin
            $error("out_symbol: expected %0d, got %0d", e.out_symbol, got.out_symbol);
            failures++;
         end
         if (got.out_count !== e.out_count) begin
            $error("out_count: expected %0d, got %0d", e.out_count, got.out_count);
            failures++;
         end
         if (got.out_rank !== e.out_rank) begin
            $error("out_rank: expected %0d, got %0d", e.out_rank, got.out_rank);
            failures++;
         end
         if (got.entry_valid !== e.entry_valid) begin
            $error("entry_valid: expected %0d, got %0d", e.entry_valid, got.entry_valid);
            failures++;
         end
         if (got.distinct_symbols !== e.distinct_symbols) begin
            $error("distinct_symbols: expected %0d, got %0d",
                   e.distinct_symbols, got.distinct_symbols);
            failures++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   freq_scoreboard sb = new();
   int unsigned    sweep_sym = 0;

   sorted_symbol_frequency_list dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_payload);
      end
   end

   function automatic req_type make_req(input logic act, input int unsigned sym,
                                        input int unsigned rnk);
      req_type r;
      r.action = act;
      r.symbol = sym[7:0];
      r.rank   = rnk[7:0];
      return r;
   endfunction

   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      int unsigned n;
      r = make_req(ACT_COUNT, $urandom_range(255), $urandom_range(255));
      n = sb.list_len;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 30) begin
         r.action = ACT_READ;
         if (n > 0 && pick < 50) r.rank = 8'($urandom_range(n - 1));
         else if (n > 0 && pick < 65) r.rank = 8'(n - 1);
         else if (pick < 75) r.rank = 8'd0;
      end else if (pick < 30) begin
         r.symbol  = sweep_sym[7:0];
         sweep_sym = (sweep_sym + 1) % 256;
      end else if (pick < 65) begin
         r.symbol = 8'($urandom_range(15)) ^ 8'h5A;
      end
      return r;
   endfunction

   task automatic issue(input req_type item, input int unsigned idle_pct);
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      sb.note_request(item);
      if ($urandom_range(99) < idle_pct) begin
         start       <= 1'b0;
         req_payload <= req_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   initial begin
      int unsigned idle_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue(make_req(ACT_READ, 8'h00, 0), 0);
      issue(make_req(ACT_READ, 8'hFF, 255), 0);
      issue(make_req(ACT_COUNT, 0, 8'hFF), 0);
      issue(make_req(ACT_COUNT, 255, 8'h00), 0);
      issue(make_req(ACT_COUNT, 255, 8'hAA), 0);
      issue(make_req(ACT_COUNT, 0, 8'h55), 0);
      issue(make_req(ACT_COUNT, 8'hAA, 0), 0);
      issue(make_req(ACT_COUNT, 8'h55, 0), 0);
      issue(make_req(ACT_READ, 8'hAA, 0), 0);
      issue(make_req(ACT_READ, 8'h55, 1), 0);
      issue(make_req(ACT_READ, 0, 2), 0);
      issue(make_req(ACT_READ, 0, 3), 0);
      issue(make_req(ACT_READ, 0, 4), 0);
      issue(make_req(ACT_COUNT, 8'h55, 0), 0);
      issue(make_req(ACT_READ, 0, 2), 0);
      issue(make_req(ACT_READ, 0, 8'hAA), 0);
      issue(make_req(ACT_READ, 0, 8'h55), 0);
      issue(make_req(ACT_COUNT, 8'hAA, 0), 0);
      issue(make_req(ACT_READ, 0, 3), 0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
         for (int k = 0; k < 542; k++) begin
            issue(random_req(), idle_pct);
         end
      end
      for (int k = 0; k < 256; k++) begin
         issue(make_req(ACT_READ, $urandom_range(255), k), 0);
      end
      start <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/sfl_pkg.sv
hdl/sfl_cell.sv
hdl/sorted_symbol_frequency_list.sv
verif/sorted_symbol_frequency_list_tb.sv
